>>> rtl/core/nsab_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and cell helpers for the nine-slice
// alpha bounding box block. No dependencies.
package nsab_pkg;

	localparam int CELLS          = 9;
	localparam int CELL_IDX_BITS  = 4;
	localparam int COORD_BITS_DEF = 12;

	// Field widths on the channels
	localparam int PIX_COORD_W = 12;
	localparam int ALPHA_W     = 8;
	localparam int SIZE_W      = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd2047;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THR   = 2'd2;

	localparam logic [SIZE_W-1:0]  CELL_WIDTH_RST  = 11'd1;
	localparam logic [SIZE_W-1:0]  CELL_HEIGHT_RST = 11'd1;
	localparam logic [ALPHA_W-1:0] ALPHA_THR_RST   = 8'd10;

	localparam logic [CELL_IDX_BITS-1:0] LAST_CELL = 4'(CELLS - 1);

	// Grid column of a cell number
	function automatic logic [1:0] cell_col(input logic [CELL_IDX_BITS-1:0] k);
		logic [1:0] c;
		case (k)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default:          c = 2'd2;
		endcase
		return c;
	endfunction

	// Grid row of a cell number
	function automatic logic [1:0] cell_row(input logic [CELL_IDX_BITS-1:0] k);
		logic [1:0] r;
		case (k)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/nsab_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, rectangle output, config writes.
// Depends on nsab_pkg for field widths.
interface nsab_pix_if;
	import nsab_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [PIX_COORD_W-1:0] pix_x;
	logic [PIX_COORD_W-1:0] pix_y;
	logic [ALPHA_W-1:0]     alpha_value;
	logic                   last_pixel;

	modport source (output valid, pix_x, pix_y, alpha_value, last_pixel, input ready);
	modport sink   (input valid, pix_x, pix_y, alpha_value, last_pixel, output ready);
endinterface

interface nsab_rect_if;
	import nsab_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CELL_IDX_BITS-1:0] cell_index;
	logic [PIX_COORD_W-1:0]   rect_left;
	logic [PIX_COORD_W-1:0]   rect_top;
	logic [SIZE_W-1:0]        rect_width;
	logic [SIZE_W-1:0]        rect_height;
	logic                     cell_found;
	logic                     last_of_run;

	modport source (output valid, cell_index, rect_left, rect_top, rect_width, rect_height,
		cell_found, last_of_run, input ready);
	modport sink   (input valid, cell_index, rect_left, rect_top, rect_width, rect_height,
		cell_found, last_of_run, output ready);
endinterface

interface nsab_cfg_if;
	import nsab_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/nine_slice_alpha_bbox.sv
`timescale 1ns / 1ps
// Nine-slice alpha bounding box: one pixel beat per cycle unless stalled, nine rectangle beats
// per image. The first rectangle follows the last pixel via the input register, the snapshot
// line and the output register, then one per cycle while rect.ready holds; per-cell boxes are
// updated in parallel lanes. A second last pixel waits in the input register until the snapshot
// of the previous image drains to its final rectangle. Reset clears found flags, valids and
// config; box coordinates are payload and need no clearing. Depends on nsab_pkg and nsab_if.
module nine_slice_alpha_bbox #(
	parameter int COORD_BITS = nsab_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nsab_pix_if.sink    pix,
	nsab_rect_if.source rect,
	nsab_cfg_if.sink    cfg
);
	import nsab_pkg::*;

	localparam int CMP_W  = (COORD_BITS > 13) ? COORD_BITS : 13;
	localparam int SPAN_W = (COORD_BITS + 1 > 12) ? COORD_BITS + 1 : 12;
	localparam int CNT_W  = $clog2(CELLS + 1);

	// Configuration
	logic [SIZE_W-1:0]  cw_q, ch_q;
	logic [ALPHA_W-1:0] thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q  <= CELL_WIDTH_RST;
			ch_q  <= CELL_HEIGHT_RST;
			thr_q <= ALPHA_THR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CELL_WIDTH:  cw_q  <= cfg.data;
				REG_CELL_HEIGHT: ch_q  <= cfg.data;
				REG_ALPHA_THR:   thr_q <= cfg.data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic                  v_s1, last_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [ALPHA_W-1:0]    a_s1;
	logic                  go_s1, snap_free, move;

	assign go_s1     = v_s1 && (!last_s1 || snap_free);
	assign pix.ready = !v_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix.ready) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			x_s1    <= COORD_BITS'(pix.pix_x);
			y_s1    <= COORD_BITS'(pix.pix_y);
			a_s1    <= pix.alpha_value;
			last_s1 <= pix.last_pixel;
		end
	end

	// Cell lookup
	logic [CMP_W-1:0]         cw1, cw2, cw3, ch1, ch2, ch3, xw, yw;
	logic [1:0]               col, row;
	logic [CELL_IDX_BITS-1:0] cell_no;
	logic                     take;

	always_comb begin
		cw1 = CMP_W'(cw_q);
		cw2 = cw1 + cw1;
		cw3 = cw2 + cw1;
		ch1 = CMP_W'(ch_q);
		ch2 = ch1 + ch1;
		ch3 = ch2 + ch1;
		xw  = CMP_W'(x_s1);
		yw  = CMP_W'(y_s1);
		if (xw < cw1)      col = 2'd0;
		else if (xw < cw2) col = 2'd1;
		else if (xw < cw3) col = 2'd2;
		else               col = 2'd3;
		if (yw < ch1)      row = 2'd0;
		else if (yw < ch2) row = 2'd1;
		else if (yw < ch3) row = 2'd2;
		else               row = 2'd3;
		cell_no = 4'({row, 1'b0}) + 4'(row) + 4'(col);
		take = go_s1 && (col != 2'd3) && (row != 2'd3) && (a_s1 > thr_q);
	end

	// Per-cell box lanes
	logic [COORD_BITS-1:0] mnx_q [CELLS], mny_q [CELLS], mxx_q [CELLS], mxy_q [CELLS];
	logic [COORD_BITS-1:0] mnx_d [CELLS], mny_d [CELLS], mxx_d [CELLS], mxy_d [CELLS];
	logic [CELLS-1:0]      seen_q, seen_d;

	always_comb begin
		for (int k = 0; k < CELLS; k++) begin
			mnx_d[k]  = mnx_q[k];
			mny_d[k]  = mny_q[k];
			mxx_d[k]  = mxx_q[k];
			mxy_d[k]  = mxy_q[k];
			seen_d[k] = seen_q[k];
			if (take && cell_no == CELL_IDX_BITS'(k)) begin
				seen_d[k] = 1'b1;
				if (!seen_q[k] || x_s1 < mnx_q[k]) mnx_d[k] = x_s1;
				if (!seen_q[k] || x_s1 > mxx_q[k]) mxx_d[k] = x_s1;
				if (!seen_q[k] || y_s1 < mny_q[k]) mny_d[k] = y_s1;
				if (!seen_q[k] || y_s1 > mxy_q[k]) mxy_d[k] = y_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (go_s1 && last_s1) begin
			seen_q <= '0;
		end else begin
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CELLS; k++) begin
			mnx_q[k] <= mnx_d[k];
			mny_q[k] <= mny_d[k];
			mxx_q[k] <= mxx_d[k];
			mxy_q[k] <= mxy_d[k];
		end
	end

	// Snapshot shift line, drained from entry 0
	logic [COORD_BITS-1:0]    snx_q [CELLS], sny_q [CELLS], sxx_q [CELLS], sxy_q [CELLS];
	logic [CELLS-1:0]         sseen_q;
	logic [CNT_W-1:0]         snap_cnt_q;
	logic [CELL_IDX_BITS-1:0] hd_q;
	logic                     out_v_q;
	logic                     load;

	assign load      = go_s1 && last_s1;
	assign move      = (snap_cnt_q != '0) && (!out_v_q || rect.ready);
	assign snap_free = (snap_cnt_q == '0) || (snap_cnt_q == CNT_W'(1) && move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_cnt_q <= '0;
			hd_q       <= '0;
		end else if (load) begin
			snap_cnt_q <= CNT_W'(CELLS);
			hd_q       <= '0;
		end else if (move) begin
			snap_cnt_q <= snap_cnt_q - CNT_W'(1);
			hd_q       <= hd_q + CELL_IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < CELLS; k++) begin
				snx_q[k] <= mnx_d[k];
				sny_q[k] <= mny_d[k];
				sxx_q[k] <= mxx_d[k];
				sxy_q[k] <= mxy_d[k];
			end
			sseen_q <= seen_d;
		end else if (move) begin
			for (int k = 0; k < CELLS - 1; k++) begin
				snx_q[k] <= snx_q[k+1];
				sny_q[k] <= sny_q[k+1];
				sxx_q[k] <= sxx_q[k+1];
				sxy_q[k] <= sxy_q[k+1];
			end
			sseen_q <= {1'b0, sseen_q[CELLS-1:1]};
		end
	end

	// Head rectangle: found box or empty-cell corner
	logic [1:0]              hcol, hrow;
	logic [12:0]             cx, cy;
	logic [COORD_BITS-1:0]   cx_m, cy_m;
	logic [SPAN_W-1:0]       dw, dh;
	logic [PIX_COORD_W-1:0]  h_left, h_top;
	logic [SIZE_W-1:0]       h_w, h_h;

	always_comb begin
		hcol = cell_col(hd_q);
		hrow = cell_row(hd_q);
		case (hcol)
			2'd0:    cx = '0;
			2'd1:    cx = 13'(cw_q);
			default: cx = 13'(cw_q) + 13'(cw_q);
		endcase
		case (hrow)
			2'd0:    cy = '0;
			2'd1:    cy = 13'(ch_q);
			default: cy = 13'(ch_q) + 13'(ch_q);
		endcase
		cx_m = COORD_BITS'(cx);
		cy_m = COORD_BITS'(cy);
		dw = SPAN_W'(sxx_q[0]) - SPAN_W'(snx_q[0]) + SPAN_W'(1);
		dh = SPAN_W'(sxy_q[0]) - SPAN_W'(sny_q[0]) + SPAN_W'(1);
		if (sseen_q[0]) begin
			h_left = PIX_COORD_W'(snx_q[0]);
			h_top  = PIX_COORD_W'(sny_q[0]);
			if (sxx_q[0] < snx_q[0])       h_w = SIZE_W'(1);
			else if (dw > SPAN_W'(SIZE_MAX)) h_w = SIZE_MAX;
			else                             h_w = SIZE_W'(dw);
			if (sxy_q[0] < sny_q[0])       h_h = SIZE_W'(1);
			else if (dh > SPAN_W'(SIZE_MAX)) h_h = SIZE_MAX;
			else                             h_h = SIZE_W'(dh);
		end else begin
			h_left = PIX_COORD_W'(cx_m);
			h_top  = PIX_COORD_W'(cy_m);
			h_w    = SIZE_W'(1);
			h_h    = SIZE_W'(1);
		end
	end

	// Output register
	logic [CELL_IDX_BITS-1:0] idx_q;
	logic [PIX_COORD_W-1:0]   left_q, top_q;
	logic [SIZE_W-1:0]        w_q, h_q;
	logic                     found_q, lor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (rect.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			idx_q   <= hd_q;
			left_q  <= h_left;
			top_q   <= h_top;
			w_q     <= h_w;
			h_q     <= h_h;
			found_q <= sseen_q[0];
			lor_q   <= (hd_q == LAST_CELL);
		end
	end

	assign rect.valid       = out_v_q;
	assign rect.cell_index  = idx_q;
	assign rect.rect_left   = left_q;
	assign rect.rect_top    = top_q;
	assign rect.rect_width  = w_q;
	assign rect.rect_height = h_q;
	assign rect.cell_found  = found_q;
	assign rect.last_of_run = lor_q;

	// Checks
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1 && !snap_free) |-> !pix.ready)
		else $error("last pixel advanced while snapshot busy");

	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (snap_cnt_q == CNT_W'(CELLS) && hd_q == '0))
		else $error("snapshot not full after load");

	a_seen_clr: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (seen_q == '0))
		else $error("found flags not cleared after last pixel");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(rect.valid && rect.last_of_run) |-> (rect.cell_index == LAST_CELL))
		else $error("last_of_run on wrong cell");

endmodule
